>>> hdl/rtss_pkg.sv
// rtss_pkg: shared types and constants of the random trigger step sequencer
// used by every module of the block but rtss_ram; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rtss_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = 1'd1;

    localparam logic [15:0] INTERNAL_PERIOD_RST = 16'd6000;
    localparam logic [11:0] PULSE_LENGTH_RST = 12'd2500;

    // loop modes
    localparam logic [1:0] LOOP_FREE = 2'd0;
    localparam logic [1:0] LOOP_16 = 2'd1;
    localparam logic [1:0] LOOP_32 = 2'd2;
    localparam logic [1:0] LOOP_ALL = 2'd3;

    // saturation limits of the control inputs
    localparam logic [6:0] PERCENT_MAX = 7'd100;
    localparam logic [2:0] RATCHET_MAX = 3'd5;

    // pitch = floor(x / 10000) with x = value * temperature * 36, by reciprocal
    localparam logic [18:0] PITCH_RECIP = 19'd429497;
    localparam int PITCH_SHIFT = 32;
    localparam logic [5:0] SEMIS = 6'd12;

    // scale rows, bit n set when semitone n belongs to the scale
    localparam logic [11:0] SCALE_MASKS [8] = '{
        12'hFFF, 12'hAB5, 12'h56B, 12'h6AD, 12'hAD5, 12'h5AB, 12'h6B5, 12'h5AD
    };

    // per-item control from the step counter front end
    typedef struct packed {
        logic       step_chg;
        logic [1:0] loop_sel;
        logic [2:0] scale_sel;
        logic [6:0] fval;
        logic [6:0] temp;
        logic [2:0] rep_arm;
    } t_front;

    // per-item result of the fire logic
    typedef struct packed {
        logic        trig;
        logic        set_note;
        logic [13:0] prod;
        logic [1:0]  loop_sel;
        logic [2:0]  scale_sel;
    } t_fire;

    // per-item data after the pitch stage
    typedef struct packed {
        logic       trig;
        logic       set_note;
        logic [5:0] pitch;
        logic [1:0] loop_sel;
        logic [2:0] scale_sel;
    } t_pitch;

endpackage

`default_nettype wire

>>> hdl/rtss_ram.sv
// rtss_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module rtss_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/rtss_front.sv
// rtss_front: step counter, clock edge detect, tick divider, buttons, read index
// depends on rtss_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtss_front #(
    parameter int STEPS = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic                     i_clock_connected,
    input  wire logic                     i_clock_high,
    input  wire logic                     i_loop_button,
    input  wire logic                     i_scale_button,
    input  wire logic [6:0]               i_density,
    input  wire logic [6:0]               i_temperature,
    input  wire logic [2:0]               i_ratchet,
    input  wire logic [6:0]               i_rand_gate,
    input  wire logic [6:0]               i_rand_value,
    input  wire logic [15:0]              i_internal_period,
    output rtss_pkg::t_front              o_front,
    output logic      [$clog2(STEPS)-1:0] o_step,
    output logic      [$clog2(STEPS)-1:0] o_rd_addr
);

    localparam int W = $clog2(STEPS);
    localparam int SW = W + 1;
    localparam logic [W-1:0] LAST = W'(STEPS - 1);
    localparam logic [SW-1:0] SPAN = SW'(STEPS);
    localparam logic [SW-1:0] OFF16 = SW'(STEPS - 16);
    localparam logic [SW-1:0] OFF32 = SW'(STEPS - 32);
    localparam logic [W-1:0] MASK16 = W'(15);
    localparam logic [W-1:0] MASK32 = W'(31);

    logic [W-1:0]  r_step;
    logic [15:0]   r_tick;
    logic          r_clock_seen;
    logic [1:0]    r_loop_sel;
    logic [W-1:0]  r_loop_origin;
    logic [2:0]    r_scale_sel;
    logic          r_loop_btn_prev;
    logic          r_scale_btn_prev;

    logic [W-1:0]  n_step;
    logic [15:0]   n_tick;
    logic          n_clock_seen;
    logic [1:0]    n_loop_sel;
    logic [W-1:0]  n_loop_origin;
    logic [2:0]    n_scale_sel;

    logic          advance;
    logic [15:0]   tick_inc;
    logic [W-1:0]  step_adv;
    logic [6:0]    dens_sat;
    logic [6:0]    temp_sat;
    logic [6:0]    rval_sat;
    logic [2:0]    rat_sat;
    logic [W-1:0]  step_mod;
    logic [SW-1:0] offset;
    logic [SW-1:0] idx_sum;
    logic [SW-1:0] idx_wrap;

    // clock edge or internal divider decides the step advance
    always_comb begin
        tick_inc = r_tick + 16'd1;
        n_tick = r_tick;
        n_clock_seen = r_clock_seen;
        advance = 1'b0;
        if (i_clock_connected) begin
            n_clock_seen = i_clock_high;
            if (i_clock_high && !r_clock_seen) begin
                advance = 1'b1;
                n_tick = '0;
            end
        end else begin
            if (tick_inc == i_internal_period) begin
                advance = 1'b1;
                n_tick = '0;
            end else begin
                n_tick = tick_inc;
            end
        end
        step_adv = (r_step >= LAST) ? '0 : r_step + W'(1);
        n_step = advance ? step_adv : r_step;
    end

    // loop and scale buttons, rising edge steps the mode
    always_comb begin
        n_loop_sel = r_loop_sel;
        n_loop_origin = r_loop_origin;
        n_scale_sel = r_scale_sel;
        if (i_loop_button && !r_loop_btn_prev) begin
            n_loop_sel = r_loop_sel + 2'd1;
            if (n_loop_sel == rtss_pkg::LOOP_16) begin
                n_loop_origin = n_step;
            end
        end
        if (i_scale_button && !r_scale_btn_prev) begin
            n_scale_sel = r_scale_sel + 3'd1;
        end
    end

    // read index relative to the loop origin
    always_comb begin
        unique case (n_loop_sel)
            rtss_pkg::LOOP_16: begin
                step_mod = n_step & MASK16;
                offset = OFF16;
            end
            rtss_pkg::LOOP_32: begin
                step_mod = n_step & MASK32;
                offset = OFF32;
            end
            default: begin
                step_mod = n_step;
                offset = '0;
            end
        endcase
        idx_sum = SW'(step_mod) + SW'(n_loop_origin) + offset;
        idx_wrap = (idx_sum >= SPAN) ? idx_sum - SPAN : idx_sum;
        o_rd_addr = (n_loop_sel == rtss_pkg::LOOP_FREE) ? n_step : idx_wrap[W-1:0];
    end

    // saturate controls and draw the free-mode value
    always_comb begin
        dens_sat = (i_density > rtss_pkg::PERCENT_MAX) ? rtss_pkg::PERCENT_MAX : i_density;
        temp_sat = (i_temperature > rtss_pkg::PERCENT_MAX) ? rtss_pkg::PERCENT_MAX
                                                           : i_temperature;
        rval_sat = (i_rand_value > rtss_pkg::PERCENT_MAX) ? rtss_pkg::PERCENT_MAX
                                                          : i_rand_value;
        rat_sat = (i_ratchet > rtss_pkg::RATCHET_MAX) ? rtss_pkg::RATCHET_MAX : i_ratchet;

        o_front.step_chg = advance;
        o_front.loop_sel = n_loop_sel;
        o_front.scale_sel = n_scale_sel;
        o_front.fval = (i_rand_gate <= dens_sat) ? rval_sat : 7'd0;
        o_front.temp = temp_sat;
        o_front.rep_arm = (rat_sat != 3'd0) ? rat_sat - 3'd1 : 3'd0;
        o_step = n_step;
    end

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_tick <= '0;
            r_clock_seen <= 1'b0;
            r_loop_sel <= rtss_pkg::LOOP_FREE;
            r_loop_origin <= '0;
            r_scale_sel <= '0;
            r_loop_btn_prev <= 1'b0;
            r_scale_btn_prev <= 1'b0;
        end else if (i_accept) begin
            r_step <= n_step;
            r_tick <= n_tick;
            r_clock_seen <= n_clock_seen;
            r_loop_sel <= n_loop_sel;
            r_loop_origin <= n_loop_origin;
            r_scale_sel <= n_scale_sel;
            r_loop_btn_prev <= i_loop_button;
            r_scale_btn_prev <= i_scale_button;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rtss_core.sv
// rtss_core: step store read-modify-write, ratchet and pulse timer
// depends on rtss_pkg; drives the write port of the step store ram
`timescale 1ns / 1ps
`default_nettype none

module rtss_core #(
    parameter int STEPS = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire rtss_pkg::t_front         i_front,
    input  wire logic [$clog2(STEPS)-1:0] i_step,
    input  wire logic [$clog2(STEPS)-1:0] i_rd_addr,
    input  wire logic [11:0]              i_pulse_length,
    input  wire logic [6:0]               i_rdata,
    input  wire logic                     i_next_ready,
    output logic                          o_ready,
    output logic                          o_fire_valid,
    output rtss_pkg::t_fire               o_fire,
    output logic                          o_we,
    output logic      [$clog2(STEPS)-1:0] o_waddr,
    output logic      [6:0]               o_wdata
);

    localparam int W = $clog2(STEPS);

    logic             r_v1;
    rtss_pkg::t_front r_f;
    logic [W-1:0]     r_step;
    logic [2:0]       r_rep;
    logic [11:0]      r_pulse;
    logic [STEPS-1:0] r_vld;
    logic             r_rd_vld;
    logic             r_fwd_hit;
    logic [6:0]       r_fwd_data;

    logic [2:0]       n_rep;
    logic [11:0]      n_pulse;
    logic [11:0]      pulse_set;
    logic             s1_move;
    logic [6:0]       stored;
    logic [6:0]       value;
    logic             set_note;
    logic             trig;

    assign s1_move = r_v1 && i_next_ready;
    assign o_ready = !r_v1 || i_next_ready;

    // free-mode write of the newly reached step
    assign o_we = s1_move && r_f.step_chg && (r_f.loop_sel == rtss_pkg::LOOP_FREE)
                  && (r_rep == 3'd0);
    assign o_waddr = r_step;
    assign o_wdata = r_f.fval;

    // stored value, forwarded when written at the edge of the read
    always_comb begin
        if (r_fwd_hit) begin
            stored = r_fwd_data;
        end else if (r_rd_vld) begin
            stored = i_rdata;
        end else begin
            stored = '0;
        end
        value = (r_f.loop_sel == rtss_pkg::LOOP_FREE) ? r_f.fval : stored;
    end

    // ratchet repeat or fresh fire, then the pulse timer
    always_comb begin
        n_rep = r_rep;
        pulse_set = r_pulse;
        set_note = 1'b0;
        if (r_f.step_chg) begin
            if (r_rep != 3'd0) begin
                n_rep = r_rep - 3'd1;
                pulse_set = i_pulse_length;
            end else if (value != 7'd0) begin
                set_note = 1'b1;
                pulse_set = i_pulse_length;
                n_rep = r_f.rep_arm;
            end
        end
        trig = (pulse_set != 12'd0);
        n_pulse = trig ? pulse_set - 12'd1 : pulse_set;

        o_fire_valid = r_v1;
        o_fire.trig = trig;
        o_fire.set_note = set_note;
        o_fire.prod = 14'({7'd0, value} * {7'd0, r_f.temp});
        o_fire.loop_sel = r_f.loop_sel;
        o_fire.scale_sel = r_f.scale_sel;
    end

    // stage register behind the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_accept) begin
            r_v1 <= 1'b1;
        end else if (s1_move) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_f <= i_front;
            r_step <= i_step;
        end
    end

    // entry valid bits and same-edge forwarding, in step with the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rd_vld <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (o_we) begin
                r_vld[o_waddr] <= 1'b1;
            end
            if (i_accept) begin
                r_rd_vld <= r_vld[i_rd_addr];
                r_fwd_hit <= o_we && (o_waddr == i_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_fwd_data <= o_wdata;
        end
    end

    // ratchet and pulse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= '0;
            r_pulse <= '0;
        end else if (s1_move) begin
            r_rep <= n_rep;
            r_pulse <= n_pulse;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rtss_note.sv
// rtss_note: pitch by reciprocal multiply, scale quantiser, held note, output register
// depends on rtss_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtss_note (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire_valid,
    input  wire rtss_pkg::t_fire i_fire,
    output logic                 o_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic                 o_trigger,
    output logic [5:0]           o_note,
    output logic [1:0]           o_loop_mode,
    output logic [2:0]           o_scale_row
);

    logic              r_v2;
    rtss_pkg::t_fire   r_s2;
    logic              r_v3;
    rtss_pkg::t_pitch  r_s3;
    logic [5:0]        r_held;

    logic              ready_out;
    logic              ready3;
    logic              move2;
    logic              move3;
    logic [18:0]       x36;
    logic [37:0]       recip_prod;
    rtss_pkg::t_pitch  n_s3;
    logic [5:0]        pitch_mod;
    logic [5:0]        quant;
    logic [5:0]        n_held;

    // bubble-collapsing handshake through the three stages
    assign ready_out = !o_out_valid || !i_out_stall;
    assign move3 = r_v3 && ready_out;
    assign ready3 = !r_v3 || ready_out;
    assign move2 = r_v2 && ready3;
    assign o_ready = !r_v2 || ready3;

    // pitch = floor(prod * 36 / 10000)
    always_comb begin
        x36 = {r_s2.prod, 5'd0} + {2'd0, r_s2.prod, 2'd0} + 19'd0;
        recip_prod = 38'({19'd0, x36} * {19'd0, rtss_pkg::PITCH_RECIP});
        n_s3.trig = r_s2.trig;
        n_s3.set_note = r_s2.set_note;
        n_s3.pitch = recip_prod[rtss_pkg::PITCH_SHIFT +: 6];
        n_s3.loop_sel = r_s2.loop_sel;
        n_s3.scale_sel = r_s2.scale_sel;
    end

    // quantise to the scale: next semitone up when out of scale
    always_comb begin
        if (r_s3.pitch < rtss_pkg::SEMIS) begin
            pitch_mod = r_s3.pitch;
        end else if (r_s3.pitch < 6'(2 * rtss_pkg::SEMIS)) begin
            pitch_mod = r_s3.pitch - rtss_pkg::SEMIS;
        end else if (r_s3.pitch < 6'(3 * rtss_pkg::SEMIS)) begin
            pitch_mod = r_s3.pitch - 6'(2 * rtss_pkg::SEMIS);
        end else begin
            pitch_mod = r_s3.pitch - 6'(3 * rtss_pkg::SEMIS);
        end
        quant = rtss_pkg::SCALE_MASKS[r_s3.scale_sel][pitch_mod[3:0]] ? r_s3.pitch
                                                                       : r_s3.pitch + 6'd1;
        n_held = r_s3.set_note ? quant : r_held;
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            o_out_valid <= 1'b0;
            r_held <= '0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_fire_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (ready_out) begin
                o_out_valid <= r_v3;
            end
            if (move3) begin
                r_held <= n_held;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (o_ready && i_fire_valid) begin
            r_s2 <= i_fire;
        end
        if (move2) begin
            r_s3 <= n_s3;
        end
        if (move3) begin
            o_trigger <= r_s3.trig;
            o_note <= n_held;
            o_loop_mode <= r_s3.loop_sel;
            o_scale_row <= r_s3.scale_sel;
        end
    end

endmodule

`default_nettype wire

>>> hdl/random_trigger_step_sequencer_top.sv
// random_trigger_step_sequencer_top: top level, configuration registers and wiring
// depends on rtss_pkg, rtss_ram, rtss_front, rtss_core, rtss_note
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------------------
//  input   | i_in_valid   | o_in_stall   | i_clock_connected .. i_rand_value
//  output  | o_out_valid  | i_out_stall  | o_trigger, o_note, o_loop_mode, o_scale_row
//  config  | i_cfg_we     | none         | i_cfg_index, i_cfg_data
//
// one item per clock while o_in_stall is low; an accepted item passes in order through
// store read and fire logic, reciprocal multiply, quantiser and output register
// the step store is a STEPS-entry ram read once per item and written at most once per item;
// a same-entry read and write on one edge is forwarded
// reset clears the store at once through per-entry valid bits, so items are taken
// from the first cycle after reset
// o_in_stall rises only when every stage holds an item and i_out_stall is high
`timescale 1ns / 1ps
`default_nettype none

module random_trigger_step_sequencer_top #(
    parameter int STEPS = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rtss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rtss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_clock_connected,
    input  wire logic                               i_clock_high,
    input  wire logic                               i_loop_button,
    input  wire logic                               i_scale_button,
    input  wire logic [6:0]                         i_density,
    input  wire logic [6:0]                         i_temperature,
    input  wire logic [2:0]                         i_ratchet,
    input  wire logic [6:0]                         i_rand_gate,
    input  wire logic [6:0]                         i_rand_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_trigger,
    output logic [5:0]                              o_note,
    output logic [1:0]                              o_loop_mode,
    output logic [2:0]                              o_scale_row
);

    localparam int W = $clog2(STEPS);

    logic [15:0]      r_internal_period;
    logic [11:0]      r_pulse_length;

    logic             accept;
    logic             core_ready;
    logic             note_ready;
    rtss_pkg::t_front front;
    logic [W-1:0]     step;
    logic [W-1:0]     rd_addr;
    logic             fire_valid;
    rtss_pkg::t_fire  fire;
    logic             ram_we;
    logic [W-1:0]     ram_waddr;
    logic [6:0]       ram_wdata;
    logic [6:0]       ram_rdata;

    assign accept = i_in_valid && core_ready;
    assign o_in_stall = !core_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_internal_period <= rtss_pkg::INTERNAL_PERIOD_RST;
            r_pulse_length <= rtss_pkg::PULSE_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtss_pkg::CFG_INTERNAL_PERIOD: r_internal_period <= i_cfg_data;
                rtss_pkg::CFG_PULSE_LENGTH:    r_pulse_length <= i_cfg_data[11:0];
            endcase
        end
    end

    rtss_front #(
        .STEPS(STEPS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_clock_connected (i_clock_connected),
        .i_clock_high      (i_clock_high),
        .i_loop_button     (i_loop_button),
        .i_scale_button    (i_scale_button),
        .i_density         (i_density),
        .i_temperature     (i_temperature),
        .i_ratchet         (i_ratchet),
        .i_rand_gate       (i_rand_gate),
        .i_rand_value      (i_rand_value),
        .i_internal_period (r_internal_period),
        .o_front           (front),
        .o_step            (step),
        .o_rd_addr         (rd_addr)
    );

    // step store
    rtss_ram #(
        .WIDTH(7),
        .DEPTH(STEPS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    rtss_core #(
        .STEPS(STEPS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_front        (front),
        .i_step         (step),
        .i_rd_addr      (rd_addr),
        .i_pulse_length (r_pulse_length),
        .i_rdata        (ram_rdata),
        .i_next_ready   (note_ready),
        .o_ready        (core_ready),
        .o_fire_valid   (fire_valid),
        .o_fire         (fire),
        .o_we           (ram_we),
        .o_waddr        (ram_waddr),
        .o_wdata        (ram_wdata)
    );

    rtss_note u_note (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire_valid (fire_valid),
        .i_fire       (fire),
        .o_ready      (note_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_trigger    (o_trigger),
        .o_note       (o_note),
        .o_loop_mode  (o_loop_mode),
        .o_scale_row  (o_scale_row)
    );

endmodule

`default_nettype wire

>>> test/tb_random_trigger_step_sequencer_top.sv
// tb_random_trigger_step_sequencer_top: self-checking testbench of the step sequencer top
// depends on rtss_pkg and random_trigger_step_sequencer_top; items queued, driven and checked
// against a cycle-free behavioural model of the sequencer kept inside the testbench
`timescale 1ns / 1ps

module tb_random_trigger_step_sequencer_top;

    localparam int STEPS = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam int MAX_REPORTS = 10;

    // scale rows, bit n set when semitone n is in the scale
    localparam logic [11:0] SCALE_ROWS [8] = '{
        12'hFFF, 12'hAB5, 12'h56B, 12'h6AD, 12'hAD5, 12'h5AB, 12'h6B5, 12'h5AD
    };

    // ways of choosing the clock source while generating items
    typedef enum int {SRC_INTERNAL, SRC_EXTERNAL, SRC_MIXED} t_clk_src;

    typedef struct packed {
        logic       connected;
        logic       clock_high;
        logic       loop_button;
        logic       scale_button;
        logic [6:0] density;
        logic [6:0] temperature;
        logic [2:0] ratchet;
        logic [6:0] rand_gate;
        logic [6:0] rand_value;
    } t_seq_tick;

    typedef struct packed {
        logic       trigger;
        logic [5:0] note;
        logic [1:0] loop_mode;
        logic [2:0] scale_row;
    } t_seq_out;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [rtss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rtss_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            trigger;
    logic [5:0]                      note;
    logic [1:0]                      loop_mode;
    logic [2:0]                      scale_row;
    t_seq_tick                       drv_tick = '0;

    t_seq_tick pending_ticks[$];
    t_seq_out  expected_outs[$];

    int  fail_count = 0;
    int  result_count = 0;
    int  quiet_cycles = 0;
    bit  last_taken = 1'b0;
    int  tx_idle_pct = 20;
    int  rx_idle_pct = 20;
    int  rx_hold_reqs = 0;
    int  rx_hold_seen = 0;
    int  rx_hold_left = 0;

    // model state
    logic [15:0] m_period;
    logic [11:0] m_pulse_len;
    logic [5:0]  m_step;
    logic [5:0]  m_prev;
    logic [15:0] m_ticks;
    logic        m_clock_seen;
    logic [1:0]  m_loop;
    logic [5:0]  m_origin;
    logic [2:0]  m_scale;
    logic [2:0]  m_repeats;
    logic [11:0] m_pulse_left;
    logic [5:0]  m_held;
    logic        m_loop_prev;
    logic        m_scale_prev;
    logic [6:0]  m_store [STEPS];

    // item generator state
    logic gen_conn = 1'b1;
    logic gen_clk = 1'b0;
    int   gen_clk_cnt = 0;
    int   gen_lb_cnt = 0;
    int   gen_sb_cnt = 0;

    random_trigger_step_sequencer_top #(
        .STEPS(STEPS)
    ) u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_clock_connected (drv_tick.connected),
        .i_clock_high      (drv_tick.clock_high),
        .i_loop_button     (drv_tick.loop_button),
        .i_scale_button    (drv_tick.scale_button),
        .i_density         (drv_tick.density),
        .i_temperature     (drv_tick.temperature),
        .i_ratchet         (drv_tick.ratchet),
        .i_rand_gate       (drv_tick.rand_gate),
        .i_rand_value      (drv_tick.rand_value),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_trigger         (trigger),
        .o_note            (note),
        .o_loop_mode       (loop_mode),
        .o_scale_row       (scale_row)
    );

    always #5 clk = ~clk;

    // one sample tick of the sequencer: updates the model state, returns the output item
    function automatic t_seq_out sequence_tick(input t_seq_tick t);
        logic [6:0]  dens;
        logic [6:0]  temp;
        logic [6:0]  rval;
        logic [2:0]  rat;
        logic [5:0]  idx;
        int unsigned size;
        int unsigned pitch;
        t_seq_out    r;
        dens = (t.density > rtss_pkg::PERCENT_MAX) ? rtss_pkg::PERCENT_MAX : t.density;
        temp = (t.temperature > rtss_pkg::PERCENT_MAX) ? rtss_pkg::PERCENT_MAX
                                                       : t.temperature;
        rval = (t.rand_value > rtss_pkg::PERCENT_MAX) ? rtss_pkg::PERCENT_MAX : t.rand_value;
        rat = (t.ratchet > rtss_pkg::RATCHET_MAX) ? rtss_pkg::RATCHET_MAX : t.ratchet;

        // step clock: external rising edge or internal divider
        if (t.connected) begin
            if (t.clock_high && !m_clock_seen) begin
                m_clock_seen = 1'b1;
                m_step = m_step + 6'd1;
                m_ticks = '0;
            end
            if (!t.clock_high)
                m_clock_seen = 1'b0;
        end else begin
            m_ticks = m_ticks + 16'd1;
            if (m_ticks == m_period) begin
                m_step = m_step + 6'd1;
                m_ticks = '0;
            end
        end

        // button edges
        if (t.loop_button && !m_loop_prev) begin
            m_loop = m_loop + 2'd1;
            if (m_loop == rtss_pkg::LOOP_16)
                m_origin = m_step;
        end
        m_loop_prev = t.loop_button;
        if (t.scale_button && !m_scale_prev)
            m_scale = m_scale + 3'd1;
        m_scale_prev = t.scale_button;

        // new step: refresh store in free mode, then fire or repeat
        if (m_step != m_prev) begin
            m_prev = m_step;
            if (m_loop == rtss_pkg::LOOP_FREE && m_repeats == 0)
                m_store[m_step] = (t.rand_gate <= dens) ? rval : 7'd0;
            case (m_loop)
                rtss_pkg::LOOP_FREE: size = STEPS;
                rtss_pkg::LOOP_16:   size = 16;
                rtss_pkg::LOOP_32:   size = 32;
                default:             size = STEPS;
            endcase
            if (m_loop == rtss_pkg::LOOP_FREE)
                idx = m_step;
            else
                idx = 6'((m_step % size) + m_origin + STEPS - size);
            if (m_repeats > 0) begin
                m_repeats = m_repeats - 3'd1;
                m_pulse_left = m_pulse_len;
            end else if (m_store[idx] > 0) begin
                pitch = (int'(m_store[idx]) * int'(temp) * 36) / 10000;
                if (SCALE_ROWS[m_scale][pitch % 12])
                    m_held = 6'(pitch);
                else
                    m_held = 6'(pitch + 1);
                m_pulse_left = m_pulse_len;
                m_repeats = (rat > 0) ? rat - 3'd1 : 3'd0;
            end
        end

        // pulse timer
        r.trigger = (m_pulse_left > 0);
        if (m_pulse_left > 0)
            m_pulse_left = m_pulse_left - 12'd1;
        r.note = m_held;
        r.loop_mode = m_loop;
        r.scale_row = m_scale;
        return r;
    endfunction

    // percent-style control, mostly in range, sometimes above the saturation point
    function automatic logic [6:0] pick_percent();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom_range(101, 127));
        return 7'($urandom_range(0, 100));
    endfunction

    task automatic push_tick(input logic conn, input logic clk_hi, input logic lbtn,
                             input logic sbtn, input logic [6:0] dens,
                             input logic [6:0] temp, input logic [2:0] rat,
                             input logic [6:0] gate, input logic [6:0] rval);
        pending_ticks.push_back('{conn, clk_hi, lbtn, sbtn, dens, temp, rat, gate, rval});
    endtask

    // queue n items: square-wave clock, held button presses, random controls, some noise
    task automatic queue_ticks(input int n, input t_clk_src src, input int half_max,
                               input int noise_pct);
        t_seq_tick t;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                t.connected    = 1'($urandom_range(0, 1));
                t.clock_high   = 1'($urandom_range(0, 1));
                t.loop_button  = 1'($urandom_range(0, 1));
                t.scale_button = 1'($urandom_range(0, 1));
                t.density      = 7'($urandom_range(0, 127));
                t.temperature  = 7'($urandom_range(0, 127));
                t.ratchet      = 3'($urandom_range(0, 7));
                t.rand_gate    = 7'($urandom_range(0, 127));
                t.rand_value   = 7'($urandom_range(0, 127));
            end else begin
                case (src)
                    SRC_INTERNAL: gen_conn = 1'b0;
                    SRC_EXTERNAL: gen_conn = 1'b1;
                    default: if ($urandom_range(0, 99) < 2) gen_conn = !gen_conn;
                endcase
                if (gen_clk_cnt == 0) begin
                    gen_clk = !gen_clk;
                    gen_clk_cnt = $urandom_range(1, half_max);
                end else begin
                    gen_clk_cnt--;
                end
                if (gen_lb_cnt > 0)
                    gen_lb_cnt--;
                else if ($urandom_range(0, 99) < 3)
                    gen_lb_cnt = $urandom_range(1, 4);
                if (gen_sb_cnt > 0)
                    gen_sb_cnt--;
                else if ($urandom_range(0, 99) < 5)
                    gen_sb_cnt = $urandom_range(1, 4);
                t.connected    = gen_conn;
                t.clock_high   = gen_clk;
                t.loop_button  = (gen_lb_cnt > 0);
                t.scale_button = (gen_sb_cnt > 0);
                t.density      = pick_percent();
                t.temperature  = pick_percent();
                t.ratchet      = 3'($urandom_range(0, 7));
                t.rand_gate    = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                             : 7'($urandom_range(0, 99));
                case ($urandom_range(0, 19))
                    0:       t.rand_value = 7'd0;
                    1, 2:    t.rand_value = 7'($urandom_range(101, 127));
                    default: t.rand_value = 7'($urandom_range(1, 100));
                endcase
            end
            pending_ticks.push_back(t);
        end
    endtask

    // register write; only called while nothing is in flight
    task automatic write_reg(input logic [rtss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == rtss_pkg::CFG_INTERNAL_PERIOD)
            m_period = data;
        else if (idx == rtss_pkg::CFG_PULSE_LENGTH)
            m_pulse_len = data[11:0];
    endtask

    // wait until every queued item is taken and every result has come back
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || expected_outs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // input driver: holds a stalled item, otherwise offers the next one or idles
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !last_taken) begin
            in_valid <= 1'b1;
        end else if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            drv_tick <= pending_ticks[0];
            in_valid <= 1'b1;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // output receiver: random stalls plus a long hold on request
    always @(negedge clk) begin
        bit hold;
        if (!rst_n) begin
            hold = 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            hold = 1'b1;
        end else if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = LONG_HOLD - 1;
            hold = 1'b1;
        end else begin
            hold = ($urandom_range(0, 99) < rx_idle_pct);
        end
        out_stall <= hold;
    end

    // monitor: checks results, predicts accepted items, watchdog
    always @(posedge clk) begin
        t_seq_out got;
        t_seq_out exp_out;
        bit       moved;
        if (!rst_n) begin
            last_taken = 1'b0;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                got.trigger = trigger;
                got.note = note;
                got.loop_mode = loop_mode;
                got.scale_row = scale_row;
                if (expected_outs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("extra result %0d: trig %0d note %0d loop %0d scale %0d",
                                 result_count, got.trigger, got.note, got.loop_mode,
                                 got.scale_row);
                end else begin
                    exp_out = expected_outs.pop_front();
                    if (got.trigger !== exp_out.trigger || got.note !== exp_out.note ||
                        got.loop_mode !== exp_out.loop_mode ||
                        got.scale_row !== exp_out.scale_row) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch %0d exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     result_count, exp_out.trigger, exp_out.note,
                                     exp_out.loop_mode, exp_out.scale_row, got.trigger,
                                     got.note, got.loop_mode, got.scale_row);
                    end
                end
                result_count++;
            end
            last_taken = in_valid && !in_stall;
            if (last_taken) begin
                moved = 1'b1;
                expected_outs.push_back(sequence_tick(drv_tick));
                void'(pending_ticks.pop_front());
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        m_period = rtss_pkg::INTERNAL_PERIOD_RST;
        m_pulse_len = rtss_pkg::PULSE_LENGTH_RST;
        m_step = '0;
        m_prev = '0;
        m_ticks = '0;
        m_clock_seen = 1'b0;
        m_loop = rtss_pkg::LOOP_FREE;
        m_origin = '0;
        m_scale = '0;
        m_repeats = '0;
        m_pulse_left = '0;
        m_held = '0;
        m_loop_prev = 1'b0;
        m_scale_prev = 1'b0;
        foreach (m_store[i]) m_store[i] = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, external clock edges, ratchet repeats, every mode
        push_tick(0, 0, 0, 0, 7'd0, 7'd0, 3'd0, 7'd0, 7'd0);
        push_tick(1, 1, 0, 0, 7'd127, 7'd127, 3'd7, 7'd0, 7'd127);
        push_tick(1, 0, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 1, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 0, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 1, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 0, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 1, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 0, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 1, 0, 0, 7'd0, 7'd0, 3'd0, 7'd127, 7'd0);
        push_tick(1, 0, 0, 0, 7'd0, 7'd0, 3'd0, 7'd0, 7'd0);
        push_tick(1, 1, 0, 0, 7'd50, 7'd73, 3'd1, 7'd50, 7'd101);
        push_tick(1, 0, 0, 1, 7'd0, 7'd0, 3'd0, 7'd0, 7'd0);
        push_tick(1, 1, 0, 0, 7'd100, 7'd100, 3'd0, 7'd99, 7'd3);
        push_tick(1, 0, 1, 0, 7'd100, 7'd100, 3'd2, 7'd0, 7'd100);
        push_tick(1, 1, 0, 0, 7'd100, 7'd100, 3'd2, 7'd0, 7'd100);
        push_tick(1, 0, 1, 0, 7'd100, 7'd100, 3'd0, 7'd0, 7'd100);
        push_tick(1, 1, 0, 0, 7'd100, 7'd100, 3'd0, 7'd0, 7'd100);
        push_tick(1, 0, 1, 0, 7'd100, 7'd100, 3'd0, 7'd0, 7'd100);
        push_tick(1, 1, 0, 0, 7'd100, 7'd100, 3'd0, 7'd0, 7'd100);
        push_tick(1, 0, 1, 0, 7'd0, 7'd0, 3'd0, 7'd0, 7'd0);
        push_tick(1, 1, 0, 0, 7'd0, 7'd50, 3'd3, 7'd0, 7'd0);
        push_tick(1, 1, 1, 1, 7'd127, 7'd127, 3'd7, 7'd127, 7'd127);
        push_tick(0, 1, 0, 0, 7'd127, 7'd127, 3'd7, 7'd127, 7'd127);
        wait_drained();

        // lowest register values, no idling on either side
        write_reg(rtss_pkg::CFG_INTERNAL_PERIOD, 16'd1);
        write_reg(rtss_pkg::CFG_PULSE_LENGTH, 16'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_ticks(250, SRC_MIXED, 3, 0);
        wait_drained();

        // highest register values
        write_reg(rtss_pkg::CFG_INTERNAL_PERIOD, 16'hFFFF);
        write_reg(rtss_pkg::CFG_PULSE_LENGTH, 16'hFFFF);
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        queue_ticks(200, SRC_MIXED, 4, 5);
        wait_drained();

        // fast internal steps; receiver holds off long while the sender keeps offering
        write_reg(rtss_pkg::CFG_INTERNAL_PERIOD, 16'd3);
        write_reg(rtss_pkg::CFG_PULSE_LENGTH, 16'd2);
        tx_idle_pct = 0;
        queue_ticks(300, SRC_INTERNAL, 2, 5);
        rx_hold_reqs++;
        wait_drained();

        // zero period and zero pulse length
        write_reg(rtss_pkg::CFG_INTERNAL_PERIOD, 16'd0);
        write_reg(rtss_pkg::CFG_PULSE_LENGTH, 16'd0);
        tx_idle_pct = 20;
        queue_ticks(150, SRC_MIXED, 3, 10);
        wait_drained();

        // random register settings, mixed clock source, some noise
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(rtss_pkg::CFG_INTERNAL_PERIOD, 16'($urandom_range(1, 12)));
            write_reg(rtss_pkg::CFG_PULSE_LENGTH, {4'($urandom_range(0, 15)),
                                                   12'($urandom_range(1, 20))});
            queue_ticks(345, SRC_MIXED, $urandom_range(1, 5), 10);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        fail_count += expected_outs.size();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
hdl/rtss_pkg.sv
hdl/rtss_ram.sv
hdl/rtss_front.sv
hdl/rtss_core.sv
hdl/rtss_note.sv
hdl/random_trigger_step_sequencer_top.sv
test/tb_random_trigger_step_sequencer_top.sv
